/* rtl/gdc_pkg.sv */
// Shared types, widths, calendar tables and divide constants for the date unit
`timescale 1ns / 1ps

package gdc_pkg;

  // Field widths of the input and result words
  localparam int MODE_W    = 2;
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int OFFSET_W  = 20;
  localparam int WEEKDAY_W = 3;
  localparam int DIFF_W    = 23;

  // Datapath widths: day numbers, quotients, multiplier operand and product
  localparam int DN_W  = 26;
  localparam int Q_W   = 20;
  localparam int B_W   = 21;
  localparam int P_W   = DN_W + B_W;
  localparam int YR_W  = 16;
  localparam int DIV_W = 3;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DN_W-1:0]    dnum_t;
  typedef logic [B_W-1:0]     mulb_t;
  typedef logic [DIV_W-1:0]   div_id_t;

  // Operation codes
  localparam mode_t MODE_WEEKDAY = 2'd0;
  localparam mode_t MODE_DIFF    = 2'd1;
  localparam mode_t MODE_ADD     = 2'd2;
  localparam mode_t MODE_NONE    = 2'd3;

  // Calendar constants
  localparam month_t MONTH_FIRST   = 4'd1;
  localparam month_t MONTH_LAST    = 4'd12;
  localparam month_t MONTH_IDX_DEC = 4'd11;
  localparam month_t MONTH_IDX_FEB = 4'd1;
  localparam month_t MONTH_MAR_MIN = 4'd2;
  localparam day_t   DAY_LAST      = 5'd31;
  localparam int     DAYS_YEAR     = 365;
  localparam int     YEARS_CENT    = 100;
  localparam int     YEARS_QUAD    = 400;
  localparam int     CENT_REM_LAST = 99;
  localparam int     QUAD_IN_CENT  = 24;

  // Saturation bounds of the difference field
  localparam logic signed [DN_W-1:0] DIFF_MAX = DN_W'(4194303);
  localparam logic signed [DN_W-1:0] DIFF_MIN = -DN_W'(4194304);

  // Constant divisors handled by the shared unit
  localparam div_id_t DIV_BY_7    = 3'd0;
  localparam div_id_t DIV_BY_100  = 3'd1;
  localparam div_id_t DIV_BY_400Y = 3'd2;
  localparam div_id_t DIV_BY_100Y = 3'd3;
  localparam div_id_t DIV_BY_4Y   = 3'd4;
  localparam div_id_t DIV_BY_1Y   = 3'd5;

  // Days before the first of a month in a common year
  function automatic logic [8:0] month_start(input month_t m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Length of a month by zero-based index, leap February included
  function automatic day_t month_len(input month_t mo, input logic leap);
    day_t v;
    unique case (mo)
      4'd0:    v = 5'd31;
      4'd1:    v = leap ? 5'd29 : 5'd28;
      4'd2:    v = 5'd31;
      4'd3:    v = 5'd30;
      4'd4:    v = 5'd31;
      4'd5:    v = 5'd30;
      4'd6:    v = 5'd31;
      4'd7:    v = 5'd31;
      4'd8:    v = 5'd30;
      4'd9:    v = 5'd31;
      4'd10:   v = 5'd30;
      4'd11:   v = 5'd31;
      default: v = 5'd31;
    endcase
    return v;
  endfunction

  function automatic mulb_t div_divisor(input div_id_t id);
    mulb_t v;
    unique case (id)
      DIV_BY_7:    v = B_W'(7);
      DIV_BY_100:  v = B_W'(100);
      DIV_BY_400Y: v = B_W'(146097);
      DIV_BY_100Y: v = B_W'(36524);
      DIV_BY_4Y:   v = B_W'(1461);
      DIV_BY_1Y:   v = B_W'(365);
      default:     v = B_W'(1);
    endcase
    return v;
  endfunction

  // Reciprocal floor(2^S / D); S covers the largest dividend of each case
  function automatic mulb_t div_recip(input div_id_t id);
    mulb_t v;
    unique case (id)
      DIV_BY_7:    v = B_W'(1198372);
      DIV_BY_100:  v = B_W'(163);
      DIV_BY_400Y: v = B_W'(229);
      DIV_BY_100Y: v = B_W'(7);
      DIV_BY_4Y:   v = B_W'(44);
      DIV_BY_1Y:   v = B_W'(5);
      default:     v = B_W'(0);
    endcase
    return v;
  endfunction

  // Quotient estimate: product shifted down by S, low by at most one
  function automatic logic [Q_W-1:0] div_est(input div_id_t id, input logic [P_W-1:0] prod);
    logic [Q_W-1:0] v;
    unique case (id)
      DIV_BY_7:    v = prod[23 +: Q_W];
      DIV_BY_100:  v = prod[14 +: Q_W];
      DIV_BY_400Y: v = prod[25 +: Q_W];
      DIV_BY_100Y: v = prod[18 +: Q_W];
      DIV_BY_4Y:   v = prod[16 +: Q_W];
      DIV_BY_1Y:   v = prod[11 +: Q_W];
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/gdc_in_if.sv */
// Input channel of the date unit: handshake and one request word
`timescale 1ns / 1ps

interface gdc_in_if;
  logic                  valid;
  logic                  ready;
  gdc_pkg::mode_t        mode;
  gdc_pkg::year_t        year_a;
  gdc_pkg::month_t       month_a;
  gdc_pkg::day_t         day_a;
  gdc_pkg::year_t        year_b;
  gdc_pkg::month_t       month_b;
  gdc_pkg::day_t         day_b;
  logic [gdc_pkg::OFFSET_W-1:0] day_offset;

  modport source (
    output valid, mode, year_a, month_a, day_a, year_b, month_b, day_b, day_offset,
    input  ready
  );
  modport sink (
    input  valid, mode, year_a, month_a, day_a, year_b, month_b, day_b, day_offset,
    output ready
  );
endinterface

/* rtl/gdc_out_if.sv */
// Result channel of the date unit: handshake and one result word
`timescale 1ns / 1ps

interface gdc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [gdc_pkg::WEEKDAY_W-1:0]        weekday;
  logic signed [gdc_pkg::DIFF_W-1:0]    day_difference;
  gdc_pkg::year_t                       result_year;
  gdc_pkg::month_t                      result_month;
  gdc_pkg::day_t                        result_day;
  logic                                 out_of_range;

  modport source (
    output valid, weekday, day_difference, result_year, result_month, result_day,
           out_of_range,
    input  ready
  );
  modport sink (
    input  valid, weekday, day_difference, result_year, result_month, result_day,
           out_of_range,
    output ready
  );
endinterface

/* rtl/gregorian_date_calculator.sv */
// Top level of the proleptic Gregorian date unit: sequencer and shared multiply-add
// The unit takes one request word at a time and returns one result word for it. Every step
// runs through a single multiply-add unit (a 26 x 21 bit product plus a 26 bit add or
// subtract) under a small sequencer. An add whose sum passes 31 December of MAX_YEAR
// stops after the limit check; otherwise the steps taken vary with the month walk of the
// result year. Constant divisions take three steps each (reciprocal estimate, remainder,
// one correction). When the result can be loaded, the sequencer returns to idle,
// where the next word is taken even while the previous result still waits on the output.
`timescale 1ns / 1ps

module gregorian_date_calculator #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input logic      clk,
  input logic      rst_n,
  gdc_in_if.sink   in_chan,
  gdc_out_if.source out_chan
);

  localparam int DN_W = gdc_pkg::DN_W;
  localparam int Q_W  = gdc_pkg::Q_W;
  localparam int B_W  = gdc_pkg::B_W;
  localparam int P_W  = gdc_pkg::P_W;
  localparam int YR_W = gdc_pkg::YR_W;

  // Day number of 31 December of MAX_YEAR
  localparam int unsigned LIM = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 +
                                MAX_YEAR / 400;
  localparam gdc_pkg::dnum_t LIM_DN  = DN_W'(LIM);
  localparam gdc_pkg::year_t MAX_Y14 = gdc_pkg::YEAR_W'(MAX_YEAR);

  // Sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_DN_P    = 5'd1;
  localparam logic [4:0] ST_DIV_EST = 5'd2;
  localparam logic [4:0] ST_DIV_REM = 5'd3;
  localparam logic [4:0] ST_DIV_FIX = 5'd4;
  localparam logic [4:0] ST_DN_365  = 5'd5;
  localparam logic [4:0] ST_DN_Q100 = 5'd6;
  localparam logic [4:0] ST_DN_Q400 = 5'd7;
  localparam logic [4:0] ST_DN_MON  = 5'd8;
  localparam logic [4:0] ST_DN_DAY  = 5'd9;
  localparam logic [4:0] ST_DIFF    = 5'd10;
  localparam logic [4:0] ST_ADD     = 5'd11;
  localparam logic [4:0] ST_LIM     = 5'd12;
  localparam logic [4:0] ST_NM1     = 5'd13;
  localparam logic [4:0] ST_YR1     = 5'd14;
  localparam logic [4:0] ST_YR2     = 5'd15;
  localparam logic [4:0] ST_MONW    = 5'd16;
  localparam logic [4:0] ST_FIN     = 5'd17;

  logic [4:0] state_r, state_nxt;

  // Captured request word
  gdc_pkg::mode_t  mode_r, mode_nxt;
  gdc_pkg::year_t  ya_r, ya_nxt, yb_r, yb_nxt;
  gdc_pkg::month_t ma_r, ma_nxt, mb_r, mb_nxt;
  gdc_pkg::day_t   da_r, da_nxt, db_r, db_nxt;
  logic [gdc_pkg::OFFSET_W-1:0] offset_r, offset_nxt;

  // Working registers
  logic                  sel_b_r, sel_b_nxt;
  gdc_pkg::dnum_t        acc_r, acc_nxt;
  logic [Q_W-1:0]        q_r, q_nxt;
  gdc_pkg::div_id_t      div_id_r, div_id_nxt;
  logic [gdc_pkg::YEAR_W-1:0] p_r, p_nxt;
  logic [7:0]            q100_r, q100_nxt;
  logic                  leap_r, leap_nxt;
  gdc_pkg::dnum_t        na_r, na_nxt;
  logic                  oor_r, oor_nxt;
  logic [7:0]            q400_r, q400_nxt;
  logic [1:0]            cen_r, cen_nxt;
  logic [4:0]            q4_r, q4_nxt;
  logic [1:0]            y1_r, y1_nxt;
  logic [YR_W-1:0]       yr_r, yr_nxt;
  gdc_pkg::month_t       mo_r, mo_nxt;

  // Result word register
  logic                          out_valid_r, out_valid_nxt;
  logic [gdc_pkg::WEEKDAY_W-1:0] wd_o_r, wd_o_nxt;
  logic [gdc_pkg::DIFF_W-1:0]    diff_o_r, diff_o_nxt;
  gdc_pkg::year_t                year_o_r, year_o_nxt;
  gdc_pkg::month_t               month_o_r, month_o_nxt;
  gdc_pkg::day_t                 day_o_r, day_o_nxt;
  logic                          oor_o_r, oor_o_nxt;

  // Shared multiply-add unit
  gdc_pkg::dnum_t ua, uc;
  gdc_pkg::mulb_t ub;
  logic           usub, ucin;
  logic [P_W-1:0] prod;
  logic [DN_W:0]  res;
  logic           borrow;

  // Selected date for the day number walk
  gdc_pkg::year_t  y_sel;
  gdc_pkg::month_t m_sel;
  gdc_pkg::day_t   d_sel;

  // Divide correction
  gdc_pkg::mulb_t  divisor;
  logic            div_clamp;
  logic            fix_ok;
  gdc_pkg::dnum_t  acc_fix;
  logic [Q_W-1:0]  q_fix;

  logic            load_out;
  logic signed [DN_W-1:0] diff_s;

  assign y_sel = sel_b_r ? yb_r : ya_r;
  assign m_sel = sel_b_r ? mb_r : ma_r;
  assign d_sel = sel_b_r ? db_r : da_r;

  assign divisor   = gdc_pkg::div_divisor(div_id_r);
  assign div_clamp = (div_id_r == gdc_pkg::DIV_BY_100Y) || (div_id_r == gdc_pkg::DIV_BY_1Y);

  // Pick the operands of the shared unit for the current step
  always_comb begin
    ua   = '0;
    ub   = '0;
    uc   = '0;
    usub = 1'b0;
    ucin = 1'b0;
    unique case (state_r)
      ST_DN_P: begin
        uc   = DN_W'(y_sel);
        ua   = DN_W'(1);
        ub   = B_W'(1);
        usub = 1'b1;
      end
      ST_DIV_EST: begin
        ua = acc_r;
        ub = gdc_pkg::div_recip(div_id_r);
      end
      ST_DIV_REM: begin
        uc   = acc_r;
        ua   = DN_W'(q_r);
        ub   = divisor;
        usub = 1'b1;
      end
      ST_DIV_FIX: begin
        uc   = acc_r;
        ua   = DN_W'(1);
        ub   = divisor;
        usub = 1'b1;
      end
      ST_DN_365: begin
        uc = DN_W'(p_r[gdc_pkg::YEAR_W-1:2]);
        ua = DN_W'(p_r);
        ub = B_W'(gdc_pkg::DAYS_YEAR);
      end
      ST_DN_Q100: begin
        uc   = acc_r;
        ua   = DN_W'(q100_r);
        ub   = B_W'(1);
        usub = 1'b1;
      end
      ST_DN_Q400: begin
        uc = acc_r;
        ua = DN_W'(q100_r[7:2]);
        ub = B_W'(1);
      end
      ST_DN_MON: begin
        uc   = acc_r;
        ua   = DN_W'(gdc_pkg::month_start(m_sel));
        ub   = B_W'(1);
        ucin = leap_r && (m_sel > gdc_pkg::MONTH_MAR_MIN);
      end
      ST_DN_DAY: begin
        uc = acc_r;
        ua = DN_W'(d_sel);
        ub = B_W'(1);
      end
      ST_DIFF: begin
        uc   = acc_r;
        ua   = na_r;
        ub   = B_W'(1);
        usub = 1'b1;
      end
      ST_ADD: begin
        uc = acc_r;
        ua = DN_W'(offset_r);
        ub = B_W'(1);
      end
      ST_LIM: begin
        uc   = LIM_DN;
        ua   = acc_r;
        ub   = B_W'(1);
        usub = 1'b1;
      end
      ST_NM1: begin
        uc   = acc_r;
        ua   = DN_W'(1);
        ub   = B_W'(1);
        usub = 1'b1;
      end
      ST_YR1: begin
        uc   = DN_W'({q4_r, y1_r});
        ua   = DN_W'(q400_r);
        ub   = B_W'(gdc_pkg::YEARS_QUAD);
        ucin = 1'b1;
      end
      ST_YR2: begin
        uc = DN_W'(yr_r);
        ua = DN_W'(cen_r);
        ub = B_W'(gdc_pkg::YEARS_CENT);
      end
      ST_MONW: begin
        uc   = acc_r;
        ua   = DN_W'(gdc_pkg::month_len(mo_r, leap_r));
        ub   = B_W'(1);
        usub = 1'b1;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  assign prod   = P_W'(ua) * P_W'(ub);
  assign res    = usub ? ({1'b0, uc} - prod[DN_W:0])
                       : ({1'b0, uc} + prod[DN_W:0] + (DN_W+1)'(ucin));
  assign borrow = res[DN_W];

  // One correction of the estimate; clamped cases stop at a quotient of three
  assign fix_ok  = !borrow && !(div_clamp && (q_r == Q_W'(3)));
  assign acc_fix = fix_ok ? res[DN_W-1:0] : acc_r;
  assign q_fix   = fix_ok ? (q_r + Q_W'(1)) : q_r;

  assign diff_s   = $signed(acc_r);
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  // Sequencer and working registers
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    ya_nxt     = ya_r;
    ma_nxt     = ma_r;
    da_nxt     = da_r;
    yb_nxt     = yb_r;
    mb_nxt     = mb_r;
    db_nxt     = db_r;
    offset_nxt = offset_r;
    sel_b_nxt  = sel_b_r;
    acc_nxt    = acc_r;
    q_nxt      = q_r;
    div_id_nxt = div_id_r;
    p_nxt      = p_r;
    q100_nxt   = q100_r;
    leap_nxt   = leap_r;
    na_nxt     = na_r;
    oor_nxt    = oor_r;
    q400_nxt   = q400_r;
    cen_nxt    = cen_r;
    q4_nxt     = q4_r;
    y1_nxt     = y1_r;
    yr_nxt     = yr_r;
    mo_nxt     = mo_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          // Take the word, folding year zero and out-of-range months
          mode_nxt   = in_chan.mode;
          ya_nxt     = (in_chan.year_a == '0) ? gdc_pkg::YEAR_W'(1) : in_chan.year_a;
          yb_nxt     = (in_chan.year_b == '0) ? gdc_pkg::YEAR_W'(1) : in_chan.year_b;
          ma_nxt     = (in_chan.month_a == '0) ? gdc_pkg::MONTH_FIRST :
                       (in_chan.month_a > gdc_pkg::MONTH_LAST) ? gdc_pkg::MONTH_LAST :
                       in_chan.month_a;
          mb_nxt     = (in_chan.month_b == '0) ? gdc_pkg::MONTH_FIRST :
                       (in_chan.month_b > gdc_pkg::MONTH_LAST) ? gdc_pkg::MONTH_LAST :
                       in_chan.month_b;
          da_nxt     = in_chan.day_a;
          db_nxt     = in_chan.day_b;
          offset_nxt = in_chan.day_offset;
          sel_b_nxt  = 1'b0;
          oor_nxt    = 1'b0;
          state_nxt  = (in_chan.mode == gdc_pkg::MODE_NONE) ? ST_FIN : ST_DN_P;
        end
      end
      ST_DN_P: begin
        p_nxt      = res[gdc_pkg::YEAR_W-1:0];
        acc_nxt    = res[DN_W-1:0];
        div_id_nxt = gdc_pkg::DIV_BY_100;
        state_nxt  = ST_DIV_EST;
      end
      ST_DIV_EST: begin
        q_nxt     = gdc_pkg::div_est(div_id_r, prod);
        state_nxt = ST_DIV_REM;
      end
      ST_DIV_REM: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        acc_nxt = acc_fix;
        q_nxt   = q_fix;
        unique case (div_id_r)
          gdc_pkg::DIV_BY_100: begin
            // Leap test of the year from (year - 1) mod 400
            q100_nxt  = q_fix[7:0];
            leap_nxt  = (p_r[1:0] == 2'd3) &&
                        ((acc_fix != DN_W'(gdc_pkg::CENT_REM_LAST)) || (q_fix[1:0] == 2'd3));
            state_nxt = ST_DN_365;
          end
          gdc_pkg::DIV_BY_7: begin
            state_nxt = ST_FIN;
          end
          gdc_pkg::DIV_BY_400Y: begin
            q400_nxt   = q_fix[7:0];
            div_id_nxt = gdc_pkg::DIV_BY_100Y;
            state_nxt  = ST_DIV_EST;
          end
          gdc_pkg::DIV_BY_100Y: begin
            cen_nxt    = q_fix[1:0];
            div_id_nxt = gdc_pkg::DIV_BY_4Y;
            state_nxt  = ST_DIV_EST;
          end
          gdc_pkg::DIV_BY_4Y: begin
            q4_nxt     = q_fix[4:0];
            div_id_nxt = gdc_pkg::DIV_BY_1Y;
            state_nxt  = ST_DIV_EST;
          end
          gdc_pkg::DIV_BY_1Y: begin
            y1_nxt    = q_fix[1:0];
            state_nxt = ST_YR1;
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_DN_365: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_DN_Q100;
      end
      ST_DN_Q100: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_DN_Q400;
      end
      ST_DN_Q400: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_DN_MON;
      end
      ST_DN_MON: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_DN_DAY;
      end
      ST_DN_DAY: begin
        acc_nxt = res[DN_W-1:0];
        unique case (mode_r)
          gdc_pkg::MODE_WEEKDAY: begin
            // Day one is a Monday, so the day number mod 7 is the weekday
            div_id_nxt = gdc_pkg::DIV_BY_7;
            state_nxt  = ST_DIV_EST;
          end
          gdc_pkg::MODE_DIFF: begin
            if (!sel_b_r) begin
              na_nxt    = res[DN_W-1:0];
              sel_b_nxt = 1'b1;
              state_nxt = ST_DN_P;
            end else begin
              state_nxt = ST_DIFF;
            end
          end
          gdc_pkg::MODE_ADD: begin
            state_nxt = ST_ADD;
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_DIFF: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_FIN;
      end
      ST_ADD: begin
        acc_nxt   = res[DN_W-1:0];
        state_nxt = ST_LIM;
      end
      ST_LIM: begin
        if (borrow) begin
          oor_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_NM1;
        end
      end
      ST_NM1: begin
        // A sum of zero stands for the first day
        acc_nxt    = borrow ? '0 : res[DN_W-1:0];
        div_id_nxt = gdc_pkg::DIV_BY_400Y;
        state_nxt  = ST_DIV_EST;
      end
      ST_YR1: begin
        yr_nxt    = res[YR_W-1:0];
        state_nxt = ST_YR2;
      end
      ST_YR2: begin
        yr_nxt    = res[YR_W-1:0];
        leap_nxt  = (y1_r == 2'd3) &&
                    ((q4_r != 5'(gdc_pkg::QUAD_IN_CENT)) || (cen_r == 2'd3));
        mo_nxt    = '0;
        state_nxt = ST_MONW;
      end
      ST_MONW: begin
        // Walk months until the remaining days fit
        if ((mo_r == gdc_pkg::MONTH_IDX_DEC) || borrow) begin
          state_nxt = ST_FIN;
        end else begin
          acc_nxt = res[DN_W-1:0];
          mo_nxt  = mo_r + 4'd1;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Pack the result word
  always_comb begin
    wd_o_nxt    = '0;
    diff_o_nxt  = '0;
    year_o_nxt  = '0;
    month_o_nxt = '0;
    day_o_nxt   = '0;
    oor_o_nxt   = 1'b0;
    unique case (mode_r)
      gdc_pkg::MODE_WEEKDAY: begin
        wd_o_nxt = acc_r[gdc_pkg::WEEKDAY_W-1:0];
      end
      gdc_pkg::MODE_DIFF: begin
        if (diff_s > gdc_pkg::DIFF_MAX) begin
          diff_o_nxt = gdc_pkg::DIFF_MAX[gdc_pkg::DIFF_W-1:0];
        end else if (diff_s < gdc_pkg::DIFF_MIN) begin
          diff_o_nxt = gdc_pkg::DIFF_MIN[gdc_pkg::DIFF_W-1:0];
        end else begin
          diff_o_nxt = acc_r[gdc_pkg::DIFF_W-1:0];
        end
      end
      gdc_pkg::MODE_ADD: begin
        if (oor_r) begin
          year_o_nxt  = MAX_Y14;
          month_o_nxt = gdc_pkg::MONTH_LAST;
          day_o_nxt   = gdc_pkg::DAY_LAST;
          oor_o_nxt   = 1'b1;
        end else begin
          year_o_nxt  = yr_r[gdc_pkg::YEAR_W-1:0];
          month_o_nxt = mo_r + 4'd1;
          day_o_nxt   = acc_r[gdc_pkg::DAY_W-1:0] + 5'd1;
        end
      end
      default: begin
        oor_o_nxt = 1'b0;
      end
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    ya_r     <= ya_nxt;
    ma_r     <= ma_nxt;
    da_r     <= da_nxt;
    yb_r     <= yb_nxt;
    mb_r     <= mb_nxt;
    db_r     <= db_nxt;
    offset_r <= offset_nxt;
    sel_b_r  <= sel_b_nxt;
    acc_r    <= acc_nxt;
    q_r      <= q_nxt;
    div_id_r <= div_id_nxt;
    p_r      <= p_nxt;
    q100_r   <= q100_nxt;
    leap_r   <= leap_nxt;
    na_r     <= na_nxt;
    oor_r    <= oor_nxt;
    q400_r   <= q400_nxt;
    cen_r    <= cen_nxt;
    q4_r     <= q4_nxt;
    y1_r     <= y1_nxt;
    yr_r     <= yr_nxt;
    mo_r     <= mo_nxt;
    if (load_out) begin
      wd_o_r    <= wd_o_nxt;
      diff_o_r  <= diff_o_nxt;
      year_o_r  <= year_o_nxt;
      month_o_r <= month_o_nxt;
      day_o_r   <= day_o_nxt;
      oor_o_r   <= oor_o_nxt;
    end
  end

  assign in_chan.ready            = (state_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.weekday         = wd_o_r;
  assign out_chan.day_difference  = $signed(diff_o_r);
  assign out_chan.result_year     = year_o_r;
  assign out_chan.result_month    = month_o_r;
  assign out_chan.result_day      = day_o_r;
  assign out_chan.out_of_range    = oor_o_r;

  // The reciprocal estimate is never more than one short
  a_est_within_one : assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_FIX) |-> (acc_r < (DN_W'(divisor) << 1))
  ) else $error("remainder before correction is two divisors or more");

  // After an unclamped correction the remainder is below the divisor
  a_rem_reduced : assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_FIX && !div_clamp) |=> (acc_r < DN_W'($past(divisor)))
  ) else $error("remainder not reduced below divisor");

  // A result word only appears out of the final step
  a_out_from_fin : assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN)
  ) else $error("result word raised outside the final step");

  // An overflowed sum always reports the last date
  a_oor_last_date : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && oor_o_r) |->
      (year_o_r == MAX_Y14 && month_o_r == gdc_pkg::MONTH_LAST &&
       day_o_r == gdc_pkg::DAY_LAST)
  ) else $error("overflow flag without the last date");

endmodule
